// File: rtl/hte_pkg.sv
// Shared types, constants and CORDIC arithmetic for the horizon to equatorial converter.
`timescale 1ns / 1ps
package hte_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int QW = 34;
    localparam int ZW = 35;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic signed [QW-1:0] KINV_Q30 = QW'(652032874);
    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd2147483648);
    localparam logic signed [2*QW-1:0] Q30_ROUND = (2*QW)'(536870912);

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335086, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41721, 32'd20860,
        32'd10430, 32'd5215, 32'd2607, 32'd1303,
        32'd651, 32'd325, 32'd162, 32'd81,
        32'd40, 32'd20, 32'd10, 32'd5,
        32'd2, 32'd1, 32'd0, 32'd0
    };

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] azimuth;
        logic signed [ANGLE_BITS-1:0] elevation;
    } hte_in_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] hour_angle;
        logic signed [ANGLE_BITS-1:0] declination;
    } hte_out_t;

    typedef struct packed {
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    typedef struct packed {
        cordic_t c;
        logic    flip;
    } rot_lane_t;

    typedef struct packed {
        logic signed [QW-1:0] ca;
        logic signed [QW-1:0] sa;
        logic signed [QW-1:0] ce;
        logic signed [QW-1:0] se;
        logic signed [QW-1:0] cl;
        logic signed [QW-1:0] sl;
    } trig_t;

    function automatic logic signed [ZW-1:0] atan_at(input int unsigned i);
        return $signed({{(ZW-32){1'b0}}, ATAN_TAB[i[4:0]]});
    endfunction

    function automatic rot_lane_t rot_pre(input logic [ANGLE_BITS-1:0] a);
        rot_lane_t l;
        logic [31:0] p;
        p = {a, {(32-ANGLE_BITS){1'b0}}};
        l.flip = p[31] ^ p[30];
        p[31] = p[31] ^ l.flip;
        l.c.x = KINV_Q30;
        l.c.y = '0;
        l.c.z = ZW'($signed(p));
        return l;
    endfunction

    function automatic cordic_t rot_step(input cordic_t c, input int unsigned i);
        cordic_t n;
        logic signed [QW-1:0] xs;
        logic signed [QW-1:0] ys;
        xs = c.x >>> i;
        ys = c.y >>> i;
        if (!c.z[ZW-1])
        begin
            n.x = c.x - ys;
            n.y = c.y + xs;
            n.z = c.z - atan_at(i);
        end
        else
        begin
            n.x = c.x + ys;
            n.y = c.y - xs;
            n.z = c.z + atan_at(i);
        end
        return n;
    endfunction

    function automatic cordic_t vec_pre(input logic signed [QW-1:0] x,
                                        input logic signed [QW-1:0] y);
        cordic_t n;
        if (x[QW-1])
        begin
            n.x = -x;
            n.y = -y;
            n.z = HALF_TURN;
        end
        else
        begin
            n.x = x;
            n.y = y;
            n.z = '0;
        end
        return n;
    endfunction

    function automatic cordic_t vec_step(input cordic_t c, input int unsigned i);
        cordic_t n;
        logic signed [QW-1:0] xs;
        logic signed [QW-1:0] ys;
        xs = c.x >>> i;
        ys = c.y >>> i;
        if (!c.y[QW-1])
        begin
            n.x = c.x + ys;
            n.y = c.y - xs;
            n.z = c.z + atan_at(i);
        end
        else
        begin
            n.x = c.x - ys;
            n.y = c.y + xs;
            n.z = c.z - atan_at(i);
        end
        return n;
    endfunction

    function automatic logic signed [QW-1:0] mul_q30(input logic signed [QW-1:0] a,
                                                     input logic signed [QW-1:0] b);
        logic signed [2*QW-1:0] p;
        p = (2*QW)'(a) * (2*QW)'(b) + Q30_ROUND;
        return p[QW+29:30];
    endfunction

    function automatic logic [ANGLE_BITS-1:0] to_out(input logic [31:0] p);
        return p[31 -: ANGLE_BITS] + ANGLE_BITS'(p[31-ANGLE_BITS]);
    endfunction

endpackage

// File: rtl/horizon_to_equatorial.sv
// Top level of the horizon to equatorial coordinate converter.
`timescale 1ns / 1ps
// Converts an azimuth and elevation pointing into hour angle and declination
// for the observatory latitude held in one configuration register.
// Commands: a beat is taken at a rising edge where start is high and busy is
// low; cmd carries azimuth and elevation as 16-bit binary angles.
// Configuration: cfg_data is written to the latitude register at an edge where
// cfg_valid and cfg_ready are both high; cfg_ready is always high. Write it
// only while no command is in flight.
// Results: done is high for exactly one cycle with result valid in that cycle;
// the receiver cannot stall, so every result is taken as it appears.
// From the accepting edge a command passes through the rotation CORDIC
// pipelines, the queue, the multiplier stages and two vectoring CORDIC
// pipelines. One command is taken every cycle while busy is low; busy rises
// only when the queue between the front and back ends is almost full.
// Reset clears the latitude to zero and empties all pipelines and the queue.
module horizon_to_equatorial #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  hte_pkg::hte_in_t                  cmd,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hte_pkg::ANGLE_BITS-1:0]    cfg_data,
    output logic                              done,
    output hte_pkg::hte_out_t                 result
);
    import hte_pkg::*;

    logic [ANGLE_BITS-1:0] latitude_reg;
    logic                  accept;
    logic                  push;
    logic                  pop;
    logic                  almost_full;
    trig_t                 front_trig;
    trig_t                 queue_trig;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign busy      = almost_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latitude_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            latitude_reg <= cfg_data;
        end
    end

    hte_front #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .cmd      (cmd),
        .latitude (latitude_reg),
        .push     (push),
        .trig     (front_trig)
    );

    hte_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .wr_data     (front_trig),
        .pop         (pop),
        .rd_data     (queue_trig),
        .almost_full (almost_full)
    );

    hte_back #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pop),
        .trig     (queue_trig),
        .done     (done),
        .result   (result)
    );

`ifndef SYNTHESIS
    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");
    a_lat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cfg_valid) |-> $stable(latitude_reg))
        else $error("latitude changed without a write");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !accept)
        else $error("command taken while busy");
`endif

endmodule

// File: rtl/hte_front.sv
// Front end: takes commands and runs three rotation CORDIC pipelines for sines and cosines.
`timescale 1ns / 1ps
module hte_front #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  hte_pkg::hte_in_t                    cmd,
    input  logic [hte_pkg::ANGLE_BITS-1:0]      latitude,
    output logic                                push,
    output hte_pkg::trig_t                      trig
);
    import hte_pkg::*;

    rot_lane_t lane_reg [0:CORDIC_STAGES][3];
    logic      valid_reg [0:CORDIC_STAGES];
    logic      push_reg;
    trig_t     trig_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= CORDIC_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            push_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= accept;
            for (int k = 0; k < CORDIC_STAGES; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
            push_reg <= valid_reg[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg[0][0] <= rot_pre(cmd.azimuth);
        lane_reg[0][1] <= rot_pre(cmd.elevation);
        lane_reg[0][2] <= rot_pre(latitude);
        for (int k = 0; k < CORDIC_STAGES; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                lane_reg[k+1][j].c    <= rot_step(lane_reg[k][j].c, k);
                lane_reg[k+1][j].flip <= lane_reg[k][j].flip;
            end
        end
        trig_reg.ca <= lane_reg[CORDIC_STAGES][0].flip ? -lane_reg[CORDIC_STAGES][0].c.x
                                                       : lane_reg[CORDIC_STAGES][0].c.x;
        trig_reg.sa <= lane_reg[CORDIC_STAGES][0].flip ? -lane_reg[CORDIC_STAGES][0].c.y
                                                       : lane_reg[CORDIC_STAGES][0].c.y;
        trig_reg.ce <= lane_reg[CORDIC_STAGES][1].flip ? -lane_reg[CORDIC_STAGES][1].c.x
                                                       : lane_reg[CORDIC_STAGES][1].c.x;
        trig_reg.se <= lane_reg[CORDIC_STAGES][1].flip ? -lane_reg[CORDIC_STAGES][1].c.y
                                                       : lane_reg[CORDIC_STAGES][1].c.y;
        trig_reg.cl <= lane_reg[CORDIC_STAGES][2].flip ? -lane_reg[CORDIC_STAGES][2].c.x
                                                       : lane_reg[CORDIC_STAGES][2].c.x;
        trig_reg.sl <= lane_reg[CORDIC_STAGES][2].flip ? -lane_reg[CORDIC_STAGES][2].c.y
                                                       : lane_reg[CORDIC_STAGES][2].c.y;
    end

    assign push = push_reg;
    assign trig = trig_reg;

endmodule

// File: rtl/hte_queue.sv
// Short queue of sine and cosine sets between the front and back ends.
`timescale 1ns / 1ps
module hte_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hte_pkg::trig_t       wr_data,
    output logic                 pop,
    output hte_pkg::trig_t       rd_data,
    output logic                 almost_full
);
    import hte_pkg::*;

    trig_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              full_reg;

    assign pop = (count_reg != '0);

    always_comb
    begin
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            full_reg   <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
            full_reg  <= (count_next >= QCNT_W'(QDEPTH - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data     = mem_reg[rd_ptr_reg];
    assign almost_full = full_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < QCNT_W'(QDEPTH)))
        else $error("queue written while full");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg) + QCNT_W'($past(push))
                  - QCNT_W'($past(pop))))
        else $error("queue count out of step");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (QPTR_W'(wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg)))
        else $error("queue pointers disagree with count");
`endif

endmodule

// File: rtl/hte_back.sv
// Back end: direction cosines, two vectoring CORDIC pipelines and output rounding.
`timescale 1ns / 1ps
module hte_back #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  hte_pkg::trig_t    trig,
    output logic              done,
    output hte_pkg::hte_out_t result
);
    import hte_pkg::*;

    localparam int NV = 2 * CORDIC_STAGES + 6;

    logic signed [QW-1:0] cc_reg, se_cl_reg, se_sl_reg, sa_ce_reg, cl_reg, sl_reg;
    logic signed [QW-1:0] cc_sl_reg, cc_cl_reg, se_cl2_reg, se_sl2_reg, sa_ce2_reg;
    logic signed [QW-1:0] x_reg, y_reg, z_reg;
    cordic_t              v1_reg [0:CORDIC_STAGES];
    logic                 pole1_reg [0:CORDIC_STAGES];
    logic signed [QW-1:0] zd_reg [0:CORDIC_STAGES];
    logic signed [QW-1:0] r_reg, zr_reg;
    logic [31:0]          har_reg;
    logic                 poler_reg;
    cordic_t              v2_reg [0:CORDIC_STAGES];
    logic                 pole2_reg [0:CORDIC_STAGES];
    logic [31:0]          ha_reg [0:CORDIC_STAGES];
    logic                 valid_reg [0:NV];
    hte_out_t             result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NV; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < NV; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cc_reg    <= mul_q30(trig.ca, trig.ce);
        se_cl_reg <= mul_q30(trig.se, trig.cl);
        se_sl_reg <= mul_q30(trig.se, trig.sl);
        sa_ce_reg <= mul_q30(trig.sa, trig.ce);
        cl_reg    <= trig.cl;
        sl_reg    <= trig.sl;

        cc_sl_reg  <= mul_q30(cc_reg, sl_reg);
        cc_cl_reg  <= mul_q30(cc_reg, cl_reg);
        se_cl2_reg <= se_cl_reg;
        se_sl2_reg <= se_sl_reg;
        sa_ce2_reg <= sa_ce_reg;

        x_reg <= se_cl2_reg - cc_sl_reg;
        y_reg <= -sa_ce2_reg;
        z_reg <= cc_cl_reg + se_sl2_reg;

        v1_reg[0]    <= vec_pre(x_reg, y_reg);
        pole1_reg[0] <= (x_reg == '0) && (y_reg == '0);
        zd_reg[0]    <= z_reg;
        for (int k = 0; k < CORDIC_STAGES; k++)
        begin
            v1_reg[k+1]    <= vec_step(v1_reg[k], k);
            pole1_reg[k+1] <= pole1_reg[k];
            zd_reg[k+1]    <= zd_reg[k];
        end

        r_reg     <= mul_q30(v1_reg[CORDIC_STAGES].x, KINV_Q30);
        har_reg   <= v1_reg[CORDIC_STAGES].z[31:0];
        poler_reg <= pole1_reg[CORDIC_STAGES];
        zr_reg    <= zd_reg[CORDIC_STAGES];

        v2_reg[0]    <= vec_pre(r_reg, zr_reg);
        pole2_reg[0] <= poler_reg;
        ha_reg[0]    <= har_reg;
        for (int k = 0; k < CORDIC_STAGES; k++)
        begin
            v2_reg[k+1]    <= vec_step(v2_reg[k], k);
            pole2_reg[k+1] <= pole2_reg[k];
            ha_reg[k+1]    <= ha_reg[k];
        end

        result_reg.hour_angle  <= pole2_reg[CORDIC_STAGES] ? '0
                                  : to_out(ha_reg[CORDIC_STAGES]);
        result_reg.declination <= to_out(v2_reg[CORDIC_STAGES].z[31:0]);
    end

    assign done   = valid_reg[NV];
    assign result = result_reg;

endmodule
